/* rtl/ctm_pkg.sv */
// Shared types and constants for the client timeout multiplexer.
package ctm_pkg;

  localparam int NumClientsDef = 8;
  localparam int PeriodW       = 27;
  localparam int ProdW         = 64 + PeriodW;
  localparam int MulSteps      = PeriodW;
  localparam int DivSteps      = 64;
  localparam int StepCntW      = 7;
  localparam logic [PeriodW-1:0] FsPerNs      = PeriodW'(1000000);
  localparam logic [PeriodW-1:0] PeriodResetFs = PeriodW'(69841279);
  localparam logic [63:0]        AllOnes      = '1;

  typedef enum logic [1:0] {
    OP_GET_TIME = 2'd0,
    OP_SET      = 2'd1,
    OP_IRQ      = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_NOTIFY = 2'd0,
    KIND_CMP    = 2'd1,
    KIND_TIME   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARITH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_CMP,
    ST_FLUSH
  } ctm_state_e;

  typedef enum logic [2:0] {
    AR_IDLE,
    AR_MUL,
    AR_CHK,
    AR_DIV,
    AR_DONE
  } arith_state_e;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  client;
    logic [63:0] value;
  } result_t;

endpackage

/* rtl/client_timeout_multiplexer_core.sv */
// Throughput: one item at a time; the shared multiply/divide unit takes 27 multiply steps
// and, unless the result saturates, 64 divide steps.
// The table scan reads one client entry at a time from the deadline RAM, in a read and a check state.
// Output stalls hold the scan; a result register lets the last result wait while idle.
// Reset (async, active low) clears all deadlines to pending-none through per-entry
// valid bits and restores the tick period register; there is no clearing pass.
module client_timeout_multiplexer_core
  import ctm_pkg::*;
#(
  parameter int NUM_CLIENTS = NumClientsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // tuser: op[1:0]
  input  logic [1:0]         s_axis_tuser_i,
  // tdata: client[2:0], delay_ns[66:3], now_ticks[130:67], zero pad[135:131]
  input  logic [135:0]       s_axis_tdata_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // tuser: kind[1:0]
  output logic [1:0]         m_axis_tuser_o,
  // tdata: target_client[2:0], value[66:3], zero pad[71:67]
  output logic [71:0]        m_axis_tdata_o,
  output logic               m_axis_tlast_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  input  logic               cfg_we_i,
  input  logic [PeriodW-1:0] cfg_wdata_i
);

  localparam int AW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int CW = $clog2(NUM_CLIENTS + 1);

  ctm_state_e state_q, state_d;

  logic [PeriodW-1:0] period_q;
  op_e                op_q, op_d;
  logic [2:0]         client_q, client_d;
  logic [63:0]        now_q, now_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [63:0]        earliest_q, earliest_d;
  logic [NUM_CLIENTS-1:0] valid_q, valid_d;
  logic               vld_rd_q, vld_rd_d;

  // Staged result waits until we know whether another one follows it.
  logic               stg_valid_q, stg_valid_d;
  result_t            stg_q, stg_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;
  logic               out_last_q, out_last_d;

  logic               can_push;
  logic               push;
  logic               push_last;

  logic               ar_start;
  logic [63:0]        ar_a;
  logic [PeriodW-1:0] ar_b, ar_d;
  logic               ar_done;
  logic [63:0]        ar_q;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [63:0]        ram_wdata, ram_rdata;

  logic               client_ok;
  logic               pending, due;
  logic [AW-1:0]      scan_addr;
  logic [AW-1:0]      client_addr;

  assign scan_addr   = AW'(idx_q);
  assign client_addr = AW'(client_q);
  assign client_ok   = 32'(client_q) < 32'(NUM_CLIENTS);
  assign pending     = vld_rd_q && (ram_rdata != AllOnes);
  assign due         = pending && (ram_rdata <= now_q);
  assign can_push    = !out_valid_q || m_axis_tready_i;

  ctm_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ar_start),
    .a_i     (ar_a),
    .b_i     (ar_b),
    .d_i     (ar_d),
    .done_o  (ar_done),
    .q_o     (ar_q)
  );

  ctm_ram #(
    .WIDTH (64),
    .DEPTH (NUM_CLIENTS)
  ) u_deadlines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    client_d    = client_q;
    now_d       = now_q;
    idx_d       = idx_q;
    earliest_d  = earliest_q;
    valid_d     = valid_q;
    vld_rd_d    = vld_rd_q;
    stg_valid_d = stg_valid_q;
    stg_d       = stg_q;
    push        = 1'b0;
    push_last   = 1'b0;
    ar_start    = 1'b0;
    ar_a        = s_axis_tdata_i[130:67];
    ar_b        = period_q;
    ar_d        = FsPerNs;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = client_addr;
    ram_wdata   = now_q + ar_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d       = op_e'(s_axis_tuser_i);
          client_d   = s_axis_tdata_i[2:0];
          now_d      = s_axis_tdata_i[130:67];
          idx_d      = '0;
          earliest_d = AllOnes;
          unique case (op_e'(s_axis_tuser_i))
            OP_GET_TIME: begin
              ar_start = 1'b1;
              state_d  = ST_ARITH;
            end
            OP_SET: begin
              ar_start = 1'b1;
              ar_a     = s_axis_tdata_i[66:3];
              ar_b     = FsPerNs;
              ar_d     = period_q;
              state_d  = ST_ARITH;
            end
            OP_IRQ: begin
              state_d = ST_SCAN_RD;
            end
            OP_NONE: begin
              state_d = ST_IDLE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ARITH: begin
        if (ar_done) begin
          if (op_q == OP_GET_TIME) begin
            stg_valid_d = 1'b1;
            stg_d       = '{kind: KIND_TIME, client: 3'd0, value: ar_q};
            state_d     = ST_FLUSH;
          end else begin
            // Store now plus delay, wrapping; out-of-range clients store nothing.
            if (client_ok) begin
              ram_we                 = 1'b1;
              valid_d[client_addr]   = 1'b1;
            end
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (32'(idx_q) == 32'(NUM_CLIENTS)) begin
          state_d = ST_CMP;
        end else begin
          ram_re   = 1'b1;
          vld_rd_d = valid_q[scan_addr];
          state_d  = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (due) begin
          // Hold here while the previous result cannot move on.
          if (!stg_valid_q || can_push) begin
            push                = stg_valid_q;
            stg_valid_d         = 1'b1;
            stg_d               = '{kind: KIND_NOTIFY, client: 3'(idx_q), value: 64'd0};
            valid_d[scan_addr]  = 1'b0;
            idx_d               = idx_q + 1'b1;
            state_d             = ST_SCAN_RD;
          end
        end else begin
          if (pending && (ram_rdata < earliest_q)) begin
            earliest_d = ram_rdata;
          end
          idx_d   = idx_q + 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_CMP: begin
        if (earliest_q != AllOnes) begin
          if (!stg_valid_q || can_push) begin
            push        = stg_valid_q;
            stg_valid_d = 1'b1;
            stg_d       = '{kind: KIND_CMP, client: 3'd0, value: earliest_q};
            state_d     = ST_FLUSH;
          end
        end else begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // Release the final result marked last; nothing staged means no results.
        if (!stg_valid_q) begin
          state_d = ST_IDLE;
        end else if (can_push) begin
          push        = 1'b1;
          push_last   = 1'b1;
          stg_valid_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register: load on push, drop once the sink takes the transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = stg_q;
      out_last_d  = push_last;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      period_q    <= PeriodResetFs;
      valid_q     <= '0;
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    client_q   <= client_d;
    now_q      <= now_d;
    idx_q      <= idx_d;
    earliest_q <= earliest_d;
    vld_rd_q   <= vld_rd_d;
    stg_q      <= stg_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {5'd0, out_q.value, out_q.client};
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* rtl/ctm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ctm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ctm_arith.sv */
// Shared shift-add multiplier and restoring divider: q = a * b / d, saturating.
module ctm_arith
  import ctm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [63:0]        a_i,
  input  logic [PeriodW-1:0] b_i,
  input  logic [PeriodW-1:0] d_i,
  output logic               done_o,
  output logic [63:0]        q_o
);

  arith_state_e state_q, state_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [ProdW-1:0]    ash_q, ash_d;
  logic [PeriodW-1:0]  bsh_q, bsh_d;
  logic [PeriodW-1:0]  d_q, d_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic                sat_q, sat_d;
  logic [PeriodW:0]    rem_sh;
  logic                ge;

  // One restoring step: remainder stays below d, so PeriodW+1 bits suffice.
  assign rem_sh = {prod_q[ProdW-1:64], prod_q[63]};
  assign ge     = rem_sh >= {1'b0, d_q};

  always_comb begin
    state_d = state_q;
    prod_d  = prod_q;
    ash_d   = ash_q;
    bsh_d   = bsh_q;
    d_d     = d_q;
    cnt_d   = cnt_q;
    sat_d   = sat_q;
    unique case (state_q)
      AR_IDLE: begin
        if (start_i) begin
          prod_d  = '0;
          ash_d   = ProdW'(a_i);
          bsh_d   = b_i;
          d_d     = d_i;
          cnt_d   = '0;
          state_d = AR_MUL;
        end
      end
      AR_MUL: begin
        if (bsh_q[0]) begin
          prod_d = prod_q + ash_q;
        end
        ash_d = ash_q << 1;
        bsh_d = bsh_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepCntW'(MulSteps - 1)) begin
          state_d = AR_CHK;
        end
      end
      AR_CHK: begin
        sat_d = (d_q == '0) || (prod_q[ProdW-1:64] >= d_q);
        cnt_d = '0;
        state_d = sat_d ? AR_DONE : AR_DIV;
      end
      AR_DIV: begin
        // Quotient bits shift into the low word as dividend bits leave it.
        prod_d[63:0] = {prod_q[62:0], ge};
        prod_d[ProdW-1:64] = ge ? PeriodW'(rem_sh - {1'b0, d_q}) : rem_sh[PeriodW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepCntW'(DivSteps - 1)) begin
          state_d = AR_DONE;
        end
      end
      AR_DONE: begin
        state_d = AR_IDLE;
      end
      default: begin
        state_d = AR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    ash_q  <= ash_d;
    bsh_q  <= bsh_d;
    d_q    <= d_d;
    cnt_q  <= cnt_d;
    sat_q  <= sat_d;
  end

  assign done_o = (state_q == AR_DONE);
  assign q_o    = sat_q ? AllOnes : prod_q[63:0];

endmodule
